@@ rtl/core/pfsra_pkg.sv @@
`timescale 1ns / 1ps

package pfsra_pkg;

  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned DATA_W    = 14;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Frame layout: even parity in bit 15, read flag in bit 14.
  localparam int unsigned PARITY_POS = 15;
  localparam int unsigned READ_POS   = 14;

  typedef enum logic [CMD_W-1:0] {
    CMD_START_READ  = 2'd0,
    CMD_START_WRITE = 2'd1,
    CMD_FRAME_RX    = 2'd2,
    CMD_UNUSED      = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_DEV_ERROR  = 2'd1,
    ST_PARITY_ERR = 2'd2,
    ST_IGNORED    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_TX   = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_CMD_SENT   = 3'd1,
    PH_DATA_SENT  = 3'd2,
    PH_REPLY_WAIT = 3'd3,
    PH_CLEAR_SENT = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOP_ADDR   = 2'd0,
    CFG_CLEAR_ADDR = 2'd1,
    CFG_ZERO_ERR   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] nop_address;
    logic [DATA_W-1:0] clear_error_address;
    logic              zero_on_error;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic              is_write;
    logic [DATA_W-1:0] pending_value;
    logic [DATA_W-1:0] captured_data;
  } eng_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [DATA_W-1:0]  address;
    logic [DATA_W-1:0]  write_value;
    logic [FRAME_W-1:0] rx_frame;
  } item_t;

  typedef struct packed {
    kind_t              kind;
    logic [FRAME_W-1:0] tx_frame;
    logic [DATA_W-1:0]  reply_data;
    status_t            status;
  } result_t;

  // Builds a frame with the read flag and even parity over bits 14:0.
  function automatic logic [FRAME_W-1:0] make_frame(input logic read_flag,
                                                    input logic [DATA_W-1:0] payload);
    logic [FRAME_W-2:0] low;
    low = {read_flag, payload};
    return {^low, low};
  endfunction

endpackage

@@ rtl/core/pfsra_step.sv @@
`timescale 1ns / 1ps

module pfsra_step
  import pfsra_pkg::*;
(
  input  eng_state_t cur,
  input  item_t      item,
  input  cfg_t       cfg,
  output eng_state_t nxt,
  output result_t    res
);

  logic ignored;
  logic rx_err;
  logic rx_par_bad;
  logic [DATA_W-1:0] done_data;

  // Starts are only taken while idle; frames only while busy.
  always_comb begin
    if (cur.phase == PH_IDLE) begin
      ignored = (item.command != CMD_START_READ) && (item.command != CMD_START_WRITE);
    end else begin
      ignored = (item.command != CMD_FRAME_RX);
    end
  end

  assign rx_err     = item.rx_frame[READ_POS];
  assign rx_par_bad = (^item.rx_frame[FRAME_W-2:0]) != item.rx_frame[PARITY_POS];

  // Next-state logic.
  always_comb begin
    nxt = cur;
    if (!ignored) begin
      unique case (cur.phase)
        PH_IDLE: begin
          nxt.phase         = PH_CMD_SENT;
          nxt.is_write      = (item.command == CMD_START_WRITE);
          nxt.pending_value = item.write_value;
        end
        PH_CMD_SENT: begin
          nxt.phase = cur.is_write ? PH_DATA_SENT : PH_REPLY_WAIT;
        end
        PH_DATA_SENT: begin
          nxt.phase = PH_REPLY_WAIT;
        end
        PH_REPLY_WAIT: begin
          nxt.captured_data = item.rx_frame[DATA_W-1:0];
          nxt.phase         = rx_err ? PH_CLEAR_SENT : PH_IDLE;
        end
        PH_CLEAR_SENT: begin
          nxt.phase = PH_IDLE;
        end
        default: begin
          nxt.phase = cur.phase;
        end
      endcase
    end
  end

  // Output logic.
  always_comb begin
    res            = '0;
    res.kind       = KIND_DONE;
    res.status     = ST_IGNORED;
    done_data      = '0;
    if (!ignored) begin
      unique case (cur.phase)
        PH_IDLE: begin
          res.kind     = KIND_TX;
          res.status   = ST_OK;
          res.tx_frame = make_frame(item.command == CMD_START_READ, item.address);
        end
        PH_CMD_SENT: begin
          res.kind     = KIND_TX;
          res.status   = ST_OK;
          res.tx_frame = make_frame(1'b0, cur.is_write ? cur.pending_value
                                                       : cfg.nop_address);
        end
        PH_DATA_SENT: begin
          res.kind     = KIND_TX;
          res.status   = ST_OK;
          res.tx_frame = make_frame(1'b0, cfg.nop_address);
        end
        PH_REPLY_WAIT: begin
          if (rx_err) begin
            res.kind     = KIND_TX;
            res.status   = ST_OK;
            res.tx_frame = make_frame(1'b1, cfg.clear_error_address);
          end else begin
            res.status = rx_par_bad ? ST_PARITY_ERR : ST_OK;
            done_data  = item.rx_frame[DATA_W-1:0];
          end
        end
        PH_CLEAR_SENT: begin
          res.status = ST_DEV_ERROR;
          done_data  = cur.captured_data;
        end
        default: begin
          res.status = ST_IGNORED;
        end
      endcase
    end
    if (res.kind == KIND_DONE) begin
      res.reply_data = (res.status != ST_OK && cfg.zero_on_error) ? '0 : done_data;
    end
  end

endmodule

@@ rtl/core/parity_framed_spi_register_access.sv @@
`timescale 1ns / 1ps

// Master-side register access engine for a sensor that speaks 16-bit frames
// with even parity in bit 15 and a read flag in bit 14.
// The host issues a start read or start write on the input channel, then
// forwards every word received from the device as a frame-received item.
// Each input transfer yields exactly one output transfer: either the next
// frame to shift out (kind 0) or the end of the transaction (kind 1) with
// the reply data and a status of ok, device error, parity error or ignored.
// Both channels use valid and stall; a transfer happens on a clock edge
// with valid high and stall low. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_wdata) and must only be written while idle.
// An input transfer passes through the input register and then the result
// register before its output is valid. The engine takes one item per cycle
// while the receiver does not stall; the only loop is the engine state
// register, updated in the same cycle that the result register loads.
// Reset (synchronous, active low) empties both registers, returns the
// engine to idle and loads the configuration defaults.
// When the receiver stalls, the result register holds its transfer, the
// input register fills behind it, and in_stall rises only when both are full.

module parity_framed_spi_register_access
  import pfsra_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [DATA_W-1:0]    in_address,
  input  logic [DATA_W-1:0]    in_write_value,
  input  logic [FRAME_W-1:0]   in_rx_frame,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [FRAME_W-1:0]   out_tx_frame,
  output logic [DATA_W-1:0]    out_reply_data,
  output logic [STATUS_W-1:0]  out_status
);

  cfg_t       cfg_r;
  eng_state_t state_r;
  eng_state_t state_nxt;
  item_t      item_r;
  logic       item_valid_r;
  result_t    res_r;
  result_t    res_nxt;
  logic       res_valid_r;
  logic       res_free;
  logic       advance;

  // The result register can load when empty or when its transfer completes.
  assign res_free = !res_valid_r || !out_stall;
  assign advance  = item_valid_r && res_free;
  assign in_stall = item_valid_r && !res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nop_address         <= '0;
      cfg_r.clear_error_address <= DATA_W'(1);
      cfg_r.zero_on_error       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NOP_ADDR:   cfg_r.nop_address         <= cfg_wdata;
        CFG_CLEAR_ADDR: cfg_r.clear_error_address <= cfg_wdata;
        CFG_ZERO_ERR:   cfg_r.zero_on_error       <= cfg_wdata[0];
        default:        cfg_r                     <= cfg_r;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!in_stall) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.command     <= in_command;
      item_r.address     <= in_address;
      item_r.write_value <= in_write_value;
      item_r.rx_frame    <= in_rx_frame;
    end
  end

  pfsra_step u_step (
    .cur  (state_r),
    .item (item_r),
    .cfg  (cfg_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Engine state advances together with the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, is_write: 1'b0, pending_value: '0, captured_data: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_free) begin
      res_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = res_valid_r;
  assign out_kind       = res_r.kind;
  assign out_tx_frame   = res_r.tx_frame;
  assign out_reply_data = res_r.reply_data;
  assign out_status     = res_r.status;

  // A finished transaction never carries a frame.
  a_done_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.kind == KIND_DONE |-> res_r.tx_frame == '0)
    else $error("finished result carries a frame");

  // Every frame handed out has even parity.
  a_tx_parity: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.kind == KIND_TX |-> (^res_r.tx_frame) == 1'b0)
    else $error("transmit frame with bad parity");

  // An ignored item leaves the phase untouched.
  a_ignored_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.status == ST_IGNORED && res_nxt.kind == KIND_DONE
      |=> state_r.phase == $past(state_r.phase))
    else $error("ignored item changed the phase");

  // A real completion returns the engine to idle.
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.kind == KIND_DONE && res_nxt.status != ST_IGNORED
      |=> state_r.phase == PH_IDLE)
    else $error("completion did not return to idle");

  // The engine state does not change while no item is held.
  a_result_with_item: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid_r |=> $stable(state_r))
    else $error("state changed without an item");

endmodule
